@@ rtl/slab_object_allocator_core_assert.svh @@
// Assertion macros for the slab object allocator.
// Used by modules that have clk and rst_n in scope; empty for synthesis.
`ifndef SLAB_OBJECT_ALLOCATOR_CORE_ASSERT_SVH
`define SLAB_OBJECT_ALLOCATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SOA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slab allocator check failed");
`define SOA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slab allocator check failed");
`else
`define SOA_ASSERT_IMP(lbl, ante, cons)
`define SOA_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ rtl/soa_pkg.sv @@
// Package for the slab object allocator: geometry constants, codes, types.
// No dependencies.
`default_nettype none
package soa_pkg;

  localparam int MAX_PAGES    = 16;
  localparam int PAGE_BYTES   = 4096;
  localparam int HEADER_BYTES = 24;
  localparam int WORD_BYTES   = 8;
  localparam int WORD_SHIFT   = $clog2(WORD_BYTES);
  localparam int SLOT_CAP     = (PAGE_BYTES - HEADER_BYTES) / WORD_BYTES;
  localparam int LINK_DEPTH   = MAX_PAGES * SLOT_CAP;
  localparam int LINK_AW      = $clog2(LINK_DEPTH);

  localparam int PAGE_W     = 4;
  localparam int SLOT_W     = 9;
  localparam int CNT_W      = 10;
  localparam int SLABS_W    = 5;
  localparam int OBJ_W      = 12;
  localparam int PAV_W      = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;
  localparam int ENT_W      = CNT_W + SLOT_W;

  localparam logic [CNT_W-1:0]     COUNT_MAX           = '1;
  localparam logic [OBJ_W-1:0]     OBJ_RESET           = OBJ_W'(8);
  localparam logic [PAV_W-1:0]     PAV_RESET           = PAV_W'(16);
  localparam logic                 KIND_ALLOC          = 1'b0;
  localparam logic                 KIND_FREE           = 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_BYTES    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGES_AVAILABLE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FREE_WR,
    ST_ALLOC_HEAD,
    ST_ALLOC_POP,
    ST_DIV,
    ST_BUILD,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [CNT_W-1:0]  cnt;
    logic [SLOT_W-1:0] head;
  } slab_ent_t;

  typedef struct packed {
    logic              we;
    logic [PAGE_W-1:0] addr;
    slab_ent_t         data;
  } tab_wr_t;

  typedef struct packed {
    logic               we;
    logic [LINK_AW-1:0] addr;
    logic [SLOT_W-1:0]  data;
  } link_wr_t;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] words;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] count;
  } div_rsp_t;

  function automatic logic [CNT_W-1:0] slot_words(input logic [OBJ_W-1:0] ob);
    logic [OBJ_W:0] v;
    logic [OBJ_W:0] s;
    v = (ob < OBJ_W'(WORD_BYTES)) ? (OBJ_W+1)'(WORD_BYTES) : {1'b0, ob};
    s = (v + (OBJ_W+1)'(WORD_BYTES - 1)) >> WORD_SHIFT;
    return s[CNT_W-1:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/soa_channels.sv @@
// Channel interfaces of the slab object allocator: request, result, config.
// Depends on soa_pkg.
`default_nettype none
interface soa_in_if import soa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [PAGE_W-1:0] free_page;
  logic [SLOT_W-1:0] free_slot;
  modport source(output valid, kind, free_page, free_slot, input ready);
  modport sink(input valid, kind, free_page, free_slot, output ready);
endinterface

interface soa_out_if import soa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              ok;
  logic [PAGE_W-1:0] page;
  logic [SLOT_W-1:0] slot;
  modport source(output valid, ok, page, slot, input ready);
  modport sink(input valid, ok, page, slot, output ready);
endinterface

interface soa_cfg_if import soa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/soa_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module soa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ rtl/soa_div.sv @@
// Restoring divider giving the slots per slab: usable page words over slot words.
// One quotient bit per cycle. Depends on soa_pkg.
`default_nettype none
module soa_div import soa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int BIT_W = $clog2(SLOT_W);
  localparam logic [SLOT_W-1:0] DIVIDEND = SLOT_W'(SLOT_CAP);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [BIT_W-1:0]  bit_r, bit_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [SLOT_W-1:0] q_r, q_nxt;
  logic [CNT_W-1:0]  words_r, words_nxt;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              fits;

  always_comb begin
    trial = {rem_r, DIVIDEND[bit_r]};
    diff  = trial - {1'b0, words_r};
    fits  = trial >= {1'b0, words_r};
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    bit_nxt   = bit_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    words_nxt = words_r;
    if (req.start) begin
      busy_nxt  = 1'b1;
      bit_nxt   = BIT_W'(SLOT_W - 1);
      rem_nxt   = '0;
      q_nxt     = '0;
      words_nxt = req.words;
    end else if (busy_r) begin
      rem_nxt    = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      q_nxt[bit_r] = fits;
      bit_nxt    = bit_r - BIT_W'(1);
      if (bit_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    bit_r   <= bit_nxt;
    rem_r   <= rem_nxt;
    q_r     <= q_nxt;
    words_r <= words_nxt;
  end

  assign rsp.done  = done_r;
  assign rsp.count = CNT_W'(q_r);

endmodule
`default_nettype wire

@@ rtl/soa_ctrl.sv @@
// Allocator sequencer: slab table and link memory read-modify-write, slab build.
// Depends on soa_pkg, soa_channels and the assertion macro header.
`default_nettype none
`include "slab_object_allocator_core_assert.svh"
module soa_ctrl import soa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  soa_in_if.sink             in_ch,
  soa_out_if.source          out_ch,
  input  logic [OBJ_W-1:0]   object_bytes,
  input  logic [PAV_W-1:0]   pages_available,
  output div_req_t           div_req,
  input  div_rsp_t           div_rsp,
  output tab_wr_t            tab_wr,
  output logic [PAGE_W-1:0]  tab_raddr,
  input  slab_ent_t          tab_rdata,
  output link_wr_t           link_wr,
  output logic [LINK_AW-1:0] link_raddr,
  input  logic [SLOT_W-1:0]  link_rdata
);

  state_t               state_r, state_nxt;
  logic [PAGE_W-1:0]    page_r, page_nxt;
  logic [SLOT_W-1:0]    slot_r, slot_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [SLOT_W-1:0]    idx_r, idx_nxt;
  logic [SLABS_W-1:0]   slabs_created_r, slabs_created_nxt;
  logic [CNT_W-1:0]     slots_per_slab_r, slots_per_slab_nxt;
  logic [MAX_PAGES-1:0] nonempty_r, nonempty_nxt;
  logic                 res_ok_r, res_ok_nxt;
  logic [PAGE_W-1:0]    res_page_r, res_page_nxt;
  logic [SLOT_W-1:0]    res_slot_r, res_slot_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_ok_r, out_ok_nxt;
  logic [PAGE_W-1:0]    out_page_r, out_page_nxt;
  logic [SLOT_W-1:0]    out_slot_r, out_slot_nxt;

  logic               in_acc;
  logic               is_free;
  logic               any_free;
  logic [PAGE_W-1:0]  enc;
  logic               free_ok;
  logic               can_grow;
  logic [CNT_W-1:0]   cnt_m1;
  logic [CNT_W-1:0]   cnt_m2;
  logic               build_last;
  logic               out_space;
  logic [LINK_AW-1:0] link_base;

  always_comb begin
    enc = '0;
    for (int i = 0; i < MAX_PAGES; i++) begin
      if (nonempty_r[i]) begin
        enc = PAGE_W'(i);
      end
    end
  end

  assign in_acc     = in_ch.valid && in_ch.ready;
  assign is_free    = in_ch.kind == KIND_FREE;
  assign any_free   = |nonempty_r;
  assign free_ok    = (SLABS_W'(in_ch.free_page) < slabs_created_r) &&
                      (CNT_W'(in_ch.free_slot) < slots_per_slab_r);
  assign can_grow   = (slabs_created_r < pages_available) &&
                      (slabs_created_r < SLABS_W'(MAX_PAGES));
  assign cnt_m1     = cnt_r - CNT_W'(1);
  assign cnt_m2     = cnt_r - CNT_W'(2);
  assign build_last = CNT_W'(idx_r) == cnt_m1;
  assign out_space  = !out_valid_r || out_ch.ready;
  assign link_base  = LINK_AW'(LINK_AW'(page_r) * LINK_AW'(SLOT_CAP));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (is_free) begin
            state_nxt = free_ok ? ST_FREE_WR : ST_RESP;
          end else if (any_free) begin
            state_nxt = ST_ALLOC_HEAD;
          end else if (!can_grow) begin
            state_nxt = ST_RESP;
          end else if (slabs_created_r == '0) begin
            state_nxt = ST_DIV;
          end else begin
            state_nxt = ST_BUILD;
          end
        end
      end
      ST_FREE_WR:    state_nxt = ST_RESP;
      ST_ALLOC_HEAD: state_nxt = ST_ALLOC_POP;
      ST_ALLOC_POP:  state_nxt = ST_RESP;
      ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = (div_rsp.count == '0) ? ST_RESP : ST_BUILD;
        end
      end
      ST_BUILD: begin
        if (build_last) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_space) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready   = state_r == ST_IDLE;
    div_req.start = (state_r == ST_IDLE) && in_acc && !is_free && !any_free &&
                    can_grow && (slabs_created_r == '0);
    div_req.words = slot_words(object_bytes);
    tab_raddr     = is_free ? in_ch.free_page : enc;
    link_raddr    = link_base + LINK_AW'(tab_rdata.head);

    link_wr.we   = 1'b0;
    link_wr.addr = link_base + LINK_AW'(slot_r);
    link_wr.data = tab_rdata.head;
    tab_wr.we    = 1'b0;
    tab_wr.addr  = page_r;
    tab_wr.data  = tab_rdata;
    case (state_r)
      ST_FREE_WR: begin
        link_wr.we        = 1'b1;
        tab_wr.we         = 1'b1;
        tab_wr.data.cnt   = (tab_rdata.cnt == COUNT_MAX) ? tab_rdata.cnt :
                            tab_rdata.cnt + CNT_W'(1);
        tab_wr.data.head  = slot_r;
      end
      ST_ALLOC_POP: begin
        tab_wr.we        = 1'b1;
        tab_wr.data.cnt  = cnt_m1;
        tab_wr.data.head = link_rdata;
      end
      ST_BUILD: begin
        link_wr.we       = 1'b1;
        link_wr.addr     = link_base + LINK_AW'(idx_r);
        link_wr.data     = (idx_r == '0) ? '0 : idx_r - SLOT_W'(1);
        tab_wr.we        = build_last;
        tab_wr.data.cnt  = cnt_m1;
        tab_wr.data.head = (cnt_r > CNT_W'(1)) ? cnt_m2[SLOT_W-1:0] : '0;
      end
      default: begin
        link_wr.we = 1'b0;
        tab_wr.we  = 1'b0;
      end
    endcase

    out_ch.valid = out_valid_r;
    out_ch.ok    = out_ok_r;
    out_ch.page  = out_page_r;
    out_ch.slot  = out_slot_r;
  end

  always_comb begin
    page_nxt           = page_r;
    slot_nxt           = slot_r;
    cnt_nxt            = cnt_r;
    idx_nxt            = idx_r;
    slabs_created_nxt  = slabs_created_r;
    slots_per_slab_nxt = slots_per_slab_r;
    nonempty_nxt       = nonempty_r;
    res_ok_nxt         = res_ok_r;
    res_page_nxt       = res_page_r;
    res_slot_nxt       = res_slot_r;
    out_valid_nxt      = out_valid_r && !out_ch.ready;
    out_ok_nxt         = out_ok_r;
    out_page_nxt       = out_page_r;
    out_slot_nxt       = out_slot_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          page_nxt     = is_free ? in_ch.free_page :
                         (any_free ? enc : slabs_created_r[PAGE_W-1:0]);
          slot_nxt     = in_ch.free_slot;
          cnt_nxt      = slots_per_slab_r;
          idx_nxt      = '0;
          res_ok_nxt   = 1'b0;
          res_page_nxt = '0;
          res_slot_nxt = '0;
        end
      end
      ST_FREE_WR: begin
        nonempty_nxt[page_r] = 1'b1;
        res_ok_nxt           = 1'b1;
      end
      ST_ALLOC_HEAD: begin
        cnt_nxt  = tab_rdata.cnt;
        slot_nxt = tab_rdata.head;
      end
      ST_ALLOC_POP: begin
        if (cnt_r == CNT_W'(1)) begin
          nonempty_nxt[page_r] = 1'b0;
        end
        res_ok_nxt   = 1'b1;
        res_page_nxt = page_r;
        res_slot_nxt = slot_r;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          cnt_nxt = div_rsp.count;
        end
      end
      ST_BUILD: begin
        idx_nxt = idx_r + SLOT_W'(1);
        if (build_last) begin
          slabs_created_nxt    = slabs_created_r + SLABS_W'(1);
          slots_per_slab_nxt   = cnt_r;
          nonempty_nxt[page_r] = cnt_r != CNT_W'(1);
          res_ok_nxt           = 1'b1;
          res_page_nxt         = page_r;
          res_slot_nxt         = cnt_m1[SLOT_W-1:0];
        end
      end
      ST_RESP: begin
        if (out_space) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = res_ok_r;
          out_page_nxt  = res_page_r;
          out_slot_nxt  = res_slot_r;
        end
      end
      default: begin
        idx_nxt = idx_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      slabs_created_r  <= '0;
      slots_per_slab_r <= '0;
      nonempty_r       <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r          <= state_nxt;
      slabs_created_r  <= slabs_created_nxt;
      slots_per_slab_r <= slots_per_slab_nxt;
      nonempty_r       <= nonempty_nxt;
      out_valid_r      <= out_valid_nxt;
    end
    page_r     <= page_nxt;
    slot_r     <= slot_nxt;
    cnt_r      <= cnt_nxt;
    idx_r      <= idx_nxt;
    res_ok_r   <= res_ok_nxt;
    res_page_r <= res_page_nxt;
    res_slot_r <= res_slot_nxt;
    out_ok_r   <= out_ok_nxt;
    out_page_r <= out_page_nxt;
    out_slot_r <= out_slot_nxt;
  end

  `SOA_ASSERT_IMP(a_nonempty_created, 1'b1, (nonempty_r >> slabs_created_r) == '0)
  `SOA_ASSERT_IMP(a_slabs_bound, 1'b1, slabs_created_r <= SLABS_W'(MAX_PAGES))
  `SOA_ASSERT_IMP(a_link_range, link_wr.we, link_wr.addr < LINK_AW'(LINK_DEPTH))
  `SOA_ASSERT_IMP(a_pop_has_slot, state_r == ST_ALLOC_HEAD, tab_rdata.cnt != '0)
  `SOA_ASSERT_NXT(a_one_item, in_ch.valid && in_ch.ready, !in_ch.ready)

endmodule
`default_nettype wire

@@ rtl/slab_object_allocator_core.sv @@
// Top level of the slab object allocator: configuration registers, memories,
// slot count divider and sequencer. Depends on soa_pkg, soa_channels, soa_ram,
// soa_div and soa_ctrl.
//
//   Channel   Role    Beat carries
//   in_ch     sink    kind, free_page, free_slot
//   out_ch    source  ok, page, slot
//   cfg_ch    sink    index, data (always ready)
//
// A valid free passes through the free write and response states from accepted beat
// to result, an allocation from a slab with free slots through the head read, pop
// and response states. A new slab links its free list in the link memory slot by
// slot (write port); the first slab also waits for the slot count division. Reset
// clears only control state; the memories are not swept. The result waits in an output
// register; a new request beat is taken once the previous result has moved into it.
`default_nettype none
module slab_object_allocator_core import soa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  soa_in_if.sink    in_ch,
  soa_out_if.source out_ch,
  soa_cfg_if.sink   cfg_ch
);

  logic [OBJ_W-1:0]   object_bytes_r, object_bytes_nxt;
  logic [PAV_W-1:0]   pages_available_r, pages_available_nxt;
  div_req_t           div_req;
  div_rsp_t           div_rsp;
  tab_wr_t            tab_wr;
  logic [PAGE_W-1:0]  tab_raddr;
  slab_ent_t          tab_rdata;
  link_wr_t           link_wr;
  logic [LINK_AW-1:0] link_raddr;
  logic [SLOT_W-1:0]  link_rdata;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    object_bytes_nxt    = object_bytes_r;
    pages_available_nxt = pages_available_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_OBJECT_BYTES:    object_bytes_nxt = cfg_ch.data[OBJ_W-1:0];
        CFG_PAGES_AVAILABLE: pages_available_nxt = cfg_ch.data[PAV_W-1:0];
        default:             object_bytes_nxt = object_bytes_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      object_bytes_r    <= OBJ_RESET;
      pages_available_r <= PAV_RESET;
    end else begin
      object_bytes_r    <= object_bytes_nxt;
      pages_available_r <= pages_available_nxt;
    end
  end

  soa_ram #(
    .WIDTH(ENT_W),
    .DEPTH(MAX_PAGES)
  ) u_tab_ram (
    .clk   (clk),
    .we    (tab_wr.we),
    .waddr (tab_wr.addr),
    .wdata (tab_wr.data),
    .raddr (tab_raddr),
    .rdata (tab_rdata)
  );

  soa_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(LINK_DEPTH)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_wr.we),
    .waddr (link_wr.addr),
    .wdata (link_wr.data),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  soa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  soa_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .object_bytes    (object_bytes_r),
    .pages_available (pages_available_r),
    .div_req         (div_req),
    .div_rsp         (div_rsp),
    .tab_wr          (tab_wr),
    .tab_raddr       (tab_raddr),
    .tab_rdata       (tab_rdata),
    .link_wr         (link_wr),
    .link_raddr      (link_raddr),
    .link_rdata      (link_rdata)
  );

endmodule
`default_nettype wire

@@ test/tb_slab_object_allocator_core.sv @@
// Testbench for slab_object_allocator_core: random and directed alloc and free
// beats checked against a cycle-free prediction of the slab free lists.
// Depends on soa_pkg, soa_channels and the allocator RTL.
module tb_slab_object_allocator_core import soa_pkg::*; ();

  localparam int unsigned RUN_LIMIT = 1_000_000;

  typedef struct packed {
    logic              kind;
    logic [PAGE_W-1:0] page;
    logic [SLOT_W-1:0] slot;
  } alloc_request_t;

  typedef struct packed {
    logic              ok;
    logic [PAGE_W-1:0] page;
    logic [SLOT_W-1:0] slot;
  } alloc_result_t;

  class slab_ledger;
    logic [OBJ_W-1:0]  obj_bytes  = OBJ_RESET;
    logic [PAV_W-1:0]  page_quota = PAV_RESET;
    int                slabs_made;
    int                slots_each;
    logic [CNT_W-1:0]  head_of [MAX_PAGES];
    logic [CNT_W-1:0]  free_cnt [MAX_PAGES];
    logic [SLOT_W-1:0] link_of [LINK_DEPTH];
    alloc_result_t     due_results [$];
    int unsigned       beats_in;
    int unsigned       granted_cnt;
    int unsigned       freed_cnt;
    int unsigned       refused_cnt;
    int unsigned       mismatches;

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      if (idx == CFG_OBJECT_BYTES) begin
        obj_bytes = value[OBJ_W-1:0];
      end else begin
        page_quota = value[PAV_W-1:0];
      end
    endfunction

    function alloc_result_t note_request(alloc_request_t req);
      alloc_result_t res;
      int            s;
      int            bytes;
      int            count;
      int            base;
      int            hd;
      res = '0;
      beats_in++;
      if (req.kind == KIND_FREE) begin
        if (int'(req.page) < slabs_made && int'(req.slot) < slots_each) begin
          link_of[int'(req.page) * SLOT_CAP + int'(req.slot)] = head_of[req.page][SLOT_W-1:0];
          head_of[req.page] = CNT_W'(req.slot);
          if (free_cnt[req.page] != COUNT_MAX) free_cnt[req.page]++;
          res.ok = 1'b1;
          freed_cnt++;
        end else begin
          refused_cnt++;
        end
        due_results.push_back(res);
        return res;
      end
      s = slabs_made - 1;
      while (s >= 0 && free_cnt[s] == '0) s--;
      if (s < 0) begin
        bytes = (int'(obj_bytes) < WORD_BYTES) ? WORD_BYTES : int'(obj_bytes);
        bytes = (bytes + WORD_BYTES - 1) / WORD_BYTES * WORD_BYTES;
        count = (slabs_made == 0) ? (PAGE_BYTES - HEADER_BYTES) / bytes : slots_each;
        if (count > SLOT_CAP) count = SLOT_CAP;
        if (slabs_made < int'(page_quota) && slabs_made < MAX_PAGES && count != 0) begin
          s = slabs_made;
          base = s * SLOT_CAP;
          link_of[base] = '0;
          for (int i = 1; i < count; i++) link_of[base + i] = SLOT_W'(i - 1);
          head_of[s] = CNT_W'(count - 1);
          free_cnt[s] = CNT_W'(count);
          slots_each = count;
          slabs_made++;
        end
      end
      if (s >= 0) begin
        base = s * SLOT_CAP;
        hd = int'(head_of[s]) % SLOT_CAP;
        head_of[s] = CNT_W'(link_of[base + hd]);
        free_cnt[s]--;
        res.ok = 1'b1;
        res.page = PAGE_W'(s);
        res.slot = SLOT_W'(hd);
        granted_cnt++;
      end else begin
        refused_cnt++;
      end
      due_results.push_back(res);
      return res;
    endfunction

    function void check_result(alloc_result_t got);
      alloc_result_t want;
      if (due_results.size() == 0) begin
        $error("Result beat with nothing expected: ok=%0d page=%0d slot=%0d",
               got.ok, got.page, got.slot);
        mismatches++;
        return;
      end
      want = due_results.pop_front();
      if (got.ok !== want.ok) begin
        $error("Field ok: expected %0d, actual %0d", want.ok, got.ok);
        mismatches++;
      end
      if (got.page !== want.page) begin
        $error("Field page: expected %0d, actual %0d", want.page, got.page);
        mismatches++;
      end
      if (got.slot !== want.slot) begin
        $error("Field slot: expected %0d, actual %0d", want.slot, got.slot);
        mismatches++;
      end
    endfunction
  endclass

  logic          clk   = 1'b0;
  logic          rst_n = 1'b0;
  slab_ledger    book  = new;
  alloc_result_t granted [$];
  alloc_result_t seen;
  int unsigned   calm_items;

  soa_in_if  in_ch ();
  soa_out_if out_ch ();
  soa_cfg_if cfg_ch ();

  slab_object_allocator_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen.ok = out_ch.ok;
      seen.page = out_ch.page;
      seen.slot = out_ch.slot;
      book.check_result(seen);
    end
  end

  initial begin : result_sink
    int unsigned stall;
    int unsigned steady;
    int unsigned pick;
    out_ch.ready = 1'b0;
    stall = 0;
    steady = 0;
    forever begin
      @(posedge clk);
      if (stall != 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (steady != 0) begin
          steady--;
        end else begin
          pick = $urandom_range(0, 99);
          if (pick == 0) stall = 0;
          if (pick == 0) steady = $urandom_range(100, 400);
          else if (pick < 15) stall = $urandom_range(1, 3);
          else if (pick < 18) stall = $urandom_range(8, 40);
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Run stopped after %0d cycles without finishing", cycle_count);
    $display("Verification failed");
    $finish;
  end

  function automatic alloc_request_t alloc_any();
    alloc_request_t req;
    req.kind = KIND_ALLOC;
    req.page = PAGE_W'($urandom);
    req.slot = SLOT_W'($urandom);
    return req;
  endfunction

  function automatic alloc_request_t free_of(int unsigned page, int unsigned slot);
    alloc_request_t req;
    req.kind = KIND_FREE;
    req.page = PAGE_W'(page);
    req.slot = SLOT_W'(slot);
    return req;
  endfunction

  task automatic push_request(alloc_request_t req);
    alloc_result_t res;
    int unsigned   gap;
    int unsigned   pick;
    in_ch.valid <= 1'b1;
    in_ch.kind <= req.kind;
    in_ch.free_page <= req.page;
    in_ch.free_slot <= req.slot;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    res = book.note_request(req);
    if (req.kind == KIND_ALLOC && res.ok) granted.push_back(res);
    gap = 0;
    if (calm_items != 0) begin
      calm_items--;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick == 0) calm_items = $urandom_range(40, 150);
      else if (pick < 40) gap = $urandom_range(1, 3);
      else if (pick < 45) gap = $urandom_range(6, 40);
    end
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic random_request(int unsigned alloc_pct);
    alloc_request_t req;
    int unsigned    pick;
    int unsigned    idx;
    req = free_of($urandom, $urandom);
    pick = $urandom_range(0, 99);
    if (pick < alloc_pct) begin
      req.kind = KIND_ALLOC;
    end else if (pick < alloc_pct + (100 - alloc_pct) * 3 / 4 && granted.size() != 0) begin
      idx = $urandom_range(0, granted.size() - 1);
      req.page = granted[idx].page;
      req.slot = granted[idx].slot;
      granted.delete(idx);
    end else if (pick % 2 == 0) begin
      req.slot = SLOT_W'($urandom_range(0, book.slots_each + 1));
    end
    push_request(req);
  endtask

  task automatic idle_request();
    in_ch.valid <= 1'b0;
  endtask

  task automatic settle();
    while (book.due_results.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= CFG_DATA_W'(value);
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    book.set_register(idx, CFG_DATA_W'(value));
  endtask

  task automatic end_config();
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned   quota_plan [6];
    int unsigned   layout;
    int unsigned   sat_frees;
    alloc_result_t victim;
    quota_plan = '{16, 1, 0, 13, 2, 16};
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_ALLOC;
    in_ch.free_page = '0;
    in_ch.free_slot = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_OBJECT_BYTES;
    cfg_ch.data = '0;
    calm_items = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // No slab exists yet, so this free names an unknown page.
    push_request(free_of(0, 0));
    idle_request();
    settle();
    write_register(CFG_PAGES_AVAILABLE, 0);
    end_config();
    push_request(alloc_any());
    idle_request();
    settle();
    write_register(CFG_PAGES_AVAILABLE, 16);
    write_register(CFG_OBJECT_BYTES, 4095);
    end_config();
    push_request(alloc_any());
    idle_request();
    settle();
    write_register(CFG_OBJECT_BYTES, 4073);
    end_config();
    push_request(alloc_any());
    idle_request();
    settle();

    // The first slab built fixes the layout for the rest of the run.
    layout = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8) : $urandom_range(600, 2040);
    write_register(CFG_OBJECT_BYTES, layout);
    end_config();
    push_request(alloc_any());
    repeat ((book.slots_each < 6) ? book.slots_each : 6) push_request(alloc_any());
    idle_request();
    settle();
    write_register(CFG_OBJECT_BYTES, 0);
    write_register(CFG_OBJECT_BYTES, 4095);
    end_config();
    push_request(alloc_any());
    push_request(free_of(15, 511));
    push_request(free_of(0, 511));
    push_request(free_of(0, book.slots_each));
    victim = granted.pop_front();
    push_request(free_of(victim.page, victim.slot));
    push_request(free_of(victim.page, victim.slot));
    push_request(alloc_any());

    for (int p = 0; p < 6; p++) begin
      idle_request();
      settle();
      if (p % 2 == 1) write_register(CFG_OBJECT_BYTES, $urandom_range(0, 4095));
      write_register(CFG_PAGES_AVAILABLE, (p == 5) ? $urandom_range(0, 16) : quota_plan[p]);
      end_config();
      repeat (60) begin
        if ($urandom_range(0, 299) == 0) begin
          idle_request();
          settle();
        end
        random_request((p % 2 == 1) ? 70 : 45);
      end
    end

    // Repeated frees on the oldest slab raise its free count, up to saturation
    // when that count already stands high.
    idle_request();
    settle();
    write_register(CFG_PAGES_AVAILABLE, 16);
    end_config();
    sat_frees = 0;
    while (book.free_cnt[0] != COUNT_MAX && sat_frees < 540) begin
      push_request(free_of(0, $urandom_range(0, book.slots_each - 1)));
      sat_frees++;
    end
    repeat (30) random_request(80);

    idle_request();
    settle();
    repeat (40) @(posedge clk);
    $display("Covered %0d request beats: %0d allocations granted, %0d frees taken, %0d refused.",
             book.beats_in, book.granted_cnt, book.freed_cnt, book.refused_cnt);
    $display("Layout held %0d slots per slab across %0d slabs.",
             book.slots_each, book.slabs_made);
    if (book.mismatches == 0 && book.due_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
